>>> rtl/assert_macros.svh
// assertion macros used by the registration table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled while reset is high
`define MRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication, disabled while reset is high
`define MRT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/mrt_pkg.sv
// types, constants and helpers for the memory region registration table
`default_nettype none

package mrt_pkg;

   localparam int MAX_RANKS      = 16;
   localparam int SLOTS_PER_RANK = 16;
   localparam int TOTAL_SLOTS    = MAX_RANKS * SLOTS_PER_RANK;
   localparam int IDX_W          = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int CNT_W          = $clog2(SLOTS_PER_RANK + 1);

   localparam int CMD_W    = 3;
   localparam int RANK_W   = 4;
   localparam int ADDR_W   = 48;
   localparam int LEN_W    = 31;
   localparam int HDL_W    = 16;
   localparam int STAT_W   = 3;
   localparam int SLOT_W   = 4;
   localparam int NRANKS_W = 5;
   localparam int END_W    = ADDR_W + 1;
   localparam int ENTRY_W  = ADDR_W + LEN_W + HDL_W;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 104;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 3'd0,
      CMD_FIND_CONT  = 3'd1,
      CMD_FIND_INTER = 3'd2,
      CMD_DELETE     = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_CONFLICT  = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_BAD_RANK  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   function automatic logic [IDX_W-1:0] slot_idx(input logic [RANK_W-1:0] rank,
                                                 input logic [SLOT_W-1:0] slot);
      return IDX_W'(IDX_W'(rank) * IDX_W'(SLOTS_PER_RANK) + IDX_W'(slot));
   endfunction

endpackage

`default_nettype wire

>>> rtl/memory_region_registration_table.sv
// memory region registration table: per-rank segment store with insert, find, delete, clear
`default_nettype none
`include "assert_macros.svh"

// One transaction at a time. Clear, unknown commands and bad ranks go from acceptance
// straight to the finish state; insert, both finds and delete first walk the 16 slots of
// the addressed rank through one registered memory read port and one segment comparator,
// one slot per cycle. The finish state registers the response once the output register is
// free. req_tready is high only while no command is in progress; a response that waits in
// the output register does not block acceptance of the next command. Valid bits live in
// flip-flops and are cleared by reset and by the clear command at once, so no clearing
// pass is needed. The lowest matching slot is reported.
module memory_region_registration_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mrt_pkg::CMD_W-1:0]       req_tuser,   // cmd
   input  logic [mrt_pkg::REQ_DATA_W-1:0]  req_tdata,   // rank, seg_addr, seg_len, seg_handle
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mrt_pkg::STAT_W-1:0]      rsp_tuser,   // status
   output logic [mrt_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // slot, entry_addr, entry_len, entry_handle
   input  logic                            csr_wr_en,
   input  logic [mrt_pkg::NRANKS_W-1:0]    csr_wr_data  // num_ranks
);
   import mrt_pkg::*;

   state_type                 state_ff, state_in;
   logic [NRANKS_W-1:0]       num_ranks_ff, num_ranks_in;
   logic [TOTAL_SLOTS-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [HDL_W-1:0]          hdl_ff, hdl_in;
   logic [END_W-1:0]          qend_ff, qend_in;
   logic                      early_ff, early_in;
   logic [STAT_W-1:0]         early_stat_ff, early_stat_in;

   logic                      hit_ff, hit_in;
   logic [SLOT_W-1:0]         hit_slot_ff, hit_slot_in;
   logic [ADDR_W-1:0]         hit_addr_ff, hit_addr_in;
   logic [LEN_W-1:0]          hit_len_ff, hit_len_in;
   logic [HDL_W-1:0]          hit_hdl_ff, hit_hdl_in;
   logic                      free_ff, free_in;
   logic [SLOT_W-1:0]         free_slot_ff, free_slot_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]         rsp_stat_ff, rsp_stat_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [LEN_W-1:0]          rsp_len_ff, rsp_len_in;
   logic [HDL_W-1:0]          rsp_hdl_ff, rsp_hdl_in;

   logic [ENTRY_W-1:0]        mem [TOTAL_SLOTS];
   logic [ENTRY_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]          rd_idx;
   logic                      mem_we;
   logic [IDX_W-1:0]          wr_idx;

   // request fields
   logic [RANK_W-1:0]         q_rank;
   logic [ADDR_W-1:0]         q_addr;
   logic [LEN_W-1:0]          q_len;
   logic [HDL_W-1:0]          q_hdl;

   // comparator
   logic [SLOT_W-1:0]         cmp_slot;
   logic                      cmp_valid;
   logic [ADDR_W-1:0]         e_base;
   logic [LEN_W-1:0]          e_len;
   logic [HDL_W-1:0]          e_hdl;
   logic [END_W-1:0]          s_end;
   logic [END_W-1:0]          a_ext;
   logic [END_W-1:0]          b_ext;
   logic                      both_zero;
   logic                      m_cont;
   logic                      m_inter;
   logic                      m_exact;
   logic                      hit_now;
   logic                      out_free;
   logic                      ins_commit;

   assign q_rank = req_tdata[RANK_W-1:0];
   assign q_addr = req_tdata[RANK_W +: ADDR_W];
   assign q_len  = req_tdata[RANK_W+ADDR_W +: LEN_W];
   assign q_hdl  = req_tdata[RANK_W+ADDR_W+LEN_W +: HDL_W];

   assign rd_idx    = slot_idx(rank_ff, cnt_ff[SLOT_W-1:0]);
   assign cmp_slot  = SLOT_W'(cnt_ff - CNT_W'(1));
   assign cmp_valid = valid_ff[slot_idx(rank_ff, cmp_slot)];
   assign e_base    = rd_data_ff[ADDR_W-1:0];
   assign e_len     = rd_data_ff[ADDR_W +: LEN_W];
   assign e_hdl     = rd_data_ff[ADDR_W+LEN_W +: HDL_W];
   assign a_ext     = END_W'(addr_ff);
   assign b_ext     = END_W'(e_base);
   assign s_end     = b_ext + END_W'(e_len);
   assign both_zero = (e_len == '0) && (len_ff == '0);
   assign m_exact   = (e_base == addr_ff);
   assign m_cont    = both_zero ? m_exact : ((b_ext <= a_ext) && (s_end >= qend_ff));
   assign m_inter   = both_zero ? m_exact :
                      (((b_ext >= a_ext) && (b_ext < qend_ff)) ||
                       ((s_end > a_ext) && (s_end <= qend_ff)));

   always_comb begin
      case (cmd_ff)
         CMD_INSERT:     hit_now = m_cont || m_inter;
         CMD_FIND_CONT:  hit_now = m_cont;
         CMD_FIND_INTER: hit_now = m_inter;
         CMD_DELETE:     hit_now = m_exact;
         default:        hit_now = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      num_ranks_in  = num_ranks_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      rank_in       = rank_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      hdl_in        = hdl_ff;
      qend_in       = qend_ff;
      early_in      = early_ff;
      early_stat_in = early_stat_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_addr_in   = hit_addr_ff;
      hit_len_in    = hit_len_ff;
      hit_hdl_in    = hit_hdl_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_stat_in   = rsp_stat_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      req_tready    = (state_ff == ST_IDLE);
      mem_we        = 1'b0;
      ins_commit    = 1'b0;
      wr_idx        = slot_idx(rank_ff, free_slot_ff);

      if (csr_wr_en) begin
         num_ranks_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_tuser;
               rank_in       = q_rank;
               addr_in       = q_addr;
               len_in        = q_len;
               hdl_in        = q_hdl;
               qend_in       = END_W'(q_addr) + ((q_len == '0) ? END_W'(1) : END_W'(q_len));
               cnt_in        = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               early_in      = 1'b1;
               early_stat_in = STAT_OK;
               state_in      = ST_FIN;
               if (req_tuser == CMD_CLEAR) begin
                  valid_in = '0;
               end else if (req_tuser > CMD_CLEAR) begin
                  early_stat_in = STAT_NOT_FOUND;
               end else if ((NRANKS_W'(q_rank) >= num_ranks_ff) ||
                            (int'(q_rank) >= MAX_RANKS)) begin
                  early_stat_in = STAT_BAD_RANK;
               end else begin
                  early_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               if (cmp_valid && hit_now && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = cmp_slot;
                  hit_addr_in = e_base;
                  hit_len_in  = e_len;
                  hit_hdl_in  = e_hdl;
               end
               if (!cmp_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = cmp_slot;
               end
            end
            if (cnt_ff == CNT_W'(SLOTS_PER_RANK)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = STAT_OK;
               rsp_slot_in  = '0;
               rsp_addr_in  = '0;
               rsp_len_in   = '0;
               rsp_hdl_in   = '0;
               state_in     = ST_IDLE;
               if (early_ff) begin
                  rsp_stat_in = early_stat_ff;
               end else if (cmd_ff == CMD_INSERT) begin
                  if (hit_ff) begin
                     rsp_stat_in = STAT_CONFLICT;
                  end else if (!free_ff) begin
                     rsp_stat_in = STAT_FULL;
                  end else begin
                     ins_commit       = 1'b1;
                     mem_we           = 1'b1;
                     valid_in[wr_idx] = 1'b1;
                     rsp_slot_in      = free_slot_ff;
                     rsp_addr_in      = addr_ff;
                     rsp_len_in       = len_ff;
                     rsp_hdl_in       = hdl_ff;
                  end
               end else if (hit_ff) begin
                  rsp_slot_in = hit_slot_ff;
                  rsp_addr_in = hit_addr_ff;
                  rsp_len_in  = hit_len_ff;
                  rsp_hdl_in  = hit_hdl_ff;
                  if (cmd_ff == CMD_DELETE) begin
                     valid_in[slot_idx(rank_ff, hit_slot_ff)] = 1'b0;
                  end
               end else begin
                  rsp_stat_in = STAT_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ranks_ff <= NRANKS_W'(MAX_RANKS);
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_ranks_ff <= num_ranks_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rank_ff       <= rank_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      hdl_ff        <= hdl_in;
      qend_ff       <= qend_in;
      early_ff      <= early_in;
      early_stat_ff <= early_stat_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_addr_ff   <= hit_addr_in;
      hit_len_ff    <= hit_len_in;
      hit_hdl_ff    <= hit_hdl_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      rsp_stat_ff   <= rsp_stat_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_hdl_ff    <= rsp_hdl_in;
   end

   // segment store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= {hdl_ff, len_ff, addr_ff};
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_hdl_ff, rsp_len_ff, rsp_addr_ff, rsp_slot_ff});

   `MRT_ASSERT(a_clear_empties, clock, reset, (req_tvalid && req_tready && (req_tuser == CMD_CLEAR)) |=> (valid_ff == '0), "clear left a valid slot")
   `MRT_ASSERT(a_insert_sets_valid, clock, reset, ins_commit |=> valid_ff[$past(wr_idx)], "inserted slot not valid")
   `MRT_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid_ff && (rsp_stat_ff != STAT_OK), (rsp_slot_ff == '0) && (rsp_addr_ff == '0) && (rsp_len_ff == '0) && (rsp_hdl_ff == '0), "failure response carries entry data")
   `MRT_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, cnt_ff <= CNT_W'(SLOTS_PER_RANK), "slot counter overran")

endmodule

`default_nettype wire
